### rtl/pgrep_pkg.sv
// Shared types and constants for the page replacement table (FIFO / LRU).
// No dependencies; used by page_replacement_fifo_lru_top.
package pgrep_pkg;

   localparam int NUM_FRAMES_DEF = 8;

   localparam int PAGE_W      = 16;
   localparam int FC_W        = 4;
   localparam int IDX_OUT_W   = 3;
   localparam int CNT_OUT_W   = 16;
   localparam int STAMP_W     = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CMP_W       = 8;

   localparam logic [FC_W-1:0]      FRAME_COUNT_RST = 4'd8;
   localparam logic [CNT_OUT_W-1:0] COUNT_MAX       = 16'hFFFF;
   localparam logic [STAMP_W-1:0]   STAMP_MAX       = 32'hFFFF_FFFF;

   // register index, taken from paddr bit 2
   localparam logic REG_FRAME_COUNT = 1'b0;
   localparam logic REG_POLICY_MODE = 1'b1;

   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

endpackage

### rtl/pgrep_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pgrep_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/page_replacement_fifo_lru_top.sv
// Fully associative page-frame table with FIFO or LRU replacement.
// Depends on pgrep_pkg and pgrep_ram (page store and use-stamp store).
//
//   port group | direction | handshake           | carries
//   req_       | in        | req_valid/req_ready | page_number, start_run
//   rsp_       | out       | rsp_valid/rsp_ready | hit, frame_index, evicted_*, counts
//   csr_       | in/out    | APB, pready = 1     | frame_count (0x0), policy_mode (0x4)
//
// A miss passes through an accept step, a scan that reads one frame per cycle
// from the page and stamp RAMs through their registered read ports, and one
// update step that writes the chosen frame.
// A hit in frame k stops the scan early.
// Synchronous active-high reset; no clearing pass, frames are tracked by valid bits.
// The update cycle holds while the previous result waits on rsp_ready; a new
// item is taken as soon as the update is done.
module page_replacement_fifo_lru_top #(
   parameter int NUM_FRAMES = pgrep_pkg::NUM_FRAMES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pgrep_pkg::PAGE_W-1:0]      req_page_number,
   input  logic                              req_start_run,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [pgrep_pkg::IDX_OUT_W-1:0]   rsp_frame_index,
   output logic                              rsp_evicted_valid,
   output logic [pgrep_pkg::PAGE_W-1:0]      rsp_evicted_page,
   output logic [pgrep_pkg::CNT_OUT_W-1:0]   rsp_fault_count,
   output logic [pgrep_pkg::CNT_OUT_W-1:0]   rsp_access_count,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pgrep_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pgrep_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pgrep_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);

   localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_W = $clog2(NUM_FRAMES + 1);

   // ---------------- configuration registers ----------------
   logic [pgrep_pkg::FC_W-1:0] csr_frame_count_ff, csr_frame_count_in;
   logic                       csr_policy_ff, csr_policy_in;
   logic                       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_frame_count_in = csr_frame_count_ff;
      csr_policy_in      = csr_policy_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            pgrep_pkg::REG_FRAME_COUNT: csr_frame_count_in = csr_pwdata[pgrep_pkg::FC_W-1:0];
            pgrep_pkg::REG_POLICY_MODE: csr_policy_in      = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         pgrep_pkg::REG_FRAME_COUNT:
            csr_prdata = pgrep_pkg::CSR_DATA_W'(csr_frame_count_ff);
         pgrep_pkg::REG_POLICY_MODE:
            csr_prdata = pgrep_pkg::CSR_DATA_W'(csr_policy_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_frame_count_ff <= pgrep_pkg::FRAME_COUNT_RST;
         csr_policy_ff      <= pgrep_pkg::POLICY_LRU;
      end else begin
         csr_frame_count_ff <= csr_frame_count_in;
         csr_policy_ff      <= csr_policy_in;
      end
   end

   logic             lru;
   logic [CNT_W-1:0] active;
   logic [CNT_W-1:0] last_idx;

   assign lru = (csr_policy_ff == pgrep_pkg::POLICY_LRU);

   always_comb begin
      if (csr_frame_count_ff == '0) begin
         active = CNT_W'(1);
      end else if (pgrep_pkg::CMP_W'(csr_frame_count_ff) > pgrep_pkg::CMP_W'(NUM_FRAMES)) begin
         active = CNT_W'(NUM_FRAMES);
      end else begin
         active = CNT_W'(csr_frame_count_ff);
      end
   end

   assign last_idx = active - CNT_W'(1);

   // ---------------- state ----------------
   pgrep_pkg::state_type state_ff, state_in;

   logic [NUM_FRAMES-1:0]           frame_valid_ff, frame_valid_in;
   logic [NUM_FRAMES-1:0]           stamp_valid_ff, stamp_valid_in;
   logic [pgrep_pkg::STAMP_W-1:0]   use_clock_ff, use_clock_in;
   logic [CNT_W-1:0]                ptr_ff, ptr_in;
   logic [pgrep_pkg::CNT_OUT_W-1:0] faults_ff, faults_in;
   logic [pgrep_pkg::CNT_OUT_W-1:0] accesses_ff, accesses_in;

   logic [pgrep_pkg::PAGE_W-1:0]    page_ff, page_in;
   logic [CNT_W-1:0]                scan_ff, scan_in;
   logic                            data_valid_ff, data_valid_in;
   logic [CNT_W-1:0]                didx_ff, didx_in;
   logic                            hit_ff, hit_in;
   logic [CNT_W-1:0]                slot_ff, slot_in;
   logic [pgrep_pkg::STAMP_W-1:0]   min_ff, min_in;
   logic [pgrep_pkg::PAGE_W-1:0]    victim_ff, victim_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_hit_ff;
   logic [pgrep_pkg::IDX_OUT_W-1:0] rsp_frame_index_ff;
   logic                            rsp_evicted_valid_ff;
   logic [pgrep_pkg::PAGE_W-1:0]    rsp_evicted_page_ff;
   logic [pgrep_pkg::CNT_OUT_W-1:0] rsp_fault_count_ff;
   logic [pgrep_pkg::CNT_OUT_W-1:0] rsp_access_count_ff;

   // ---------------- memories ----------------
   logic                          issue;
   logic [pgrep_pkg::PAGE_W-1:0]  page_rd;
   logic [pgrep_pkg::STAMP_W-1:0] stamp_rd;
   logic                          page_wr, stamp_wr;
   logic [CNT_W-1:0]              slot;
   logic [pgrep_pkg::STAMP_W-1:0] stamp_next;

   pgrep_ram #(.WIDTH(pgrep_pkg::PAGE_W), .DEPTH(NUM_FRAMES)) u_page_ram (
      .clock   (clock),
      .wr_en   (page_wr),
      .wr_addr (slot[IDX_W-1:0]),
      .wr_data (page_ff),
      .rd_en   (issue),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (page_rd)
   );

   pgrep_ram #(.WIDTH(pgrep_pkg::STAMP_W), .DEPTH(NUM_FRAMES)) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_wr),
      .wr_addr (slot[IDX_W-1:0]),
      .wr_data (stamp_next),
      .rd_en   (issue),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (stamp_rd)
   );

   // ---------------- shared compare unit ----------------
   logic                          req_fire;
   logic                          upd_go;
   logic                          match;
   logic                          scan_last;
   logic                          take_min;
   logic [pgrep_pkg::STAMP_W-1:0] stamp_cur;
   logic [CNT_W-1:0]              fifo_slot;
   logic [CNT_W-1:0]              slot_plus;
   logic                          ev_valid;

   assign req_fire  = req_valid && req_ready;
   assign match     = data_valid_ff && frame_valid_ff[didx_ff[IDX_W-1:0]]
                      && (page_rd == page_ff);
   assign scan_last = data_valid_ff && (didx_ff == last_idx);
   // a stamp never written since the run start reads as zero
   assign stamp_cur = stamp_valid_ff[didx_ff[IDX_W-1:0]] ? stamp_rd : '0;
   assign take_min  = (didx_ff == '0) || (stamp_cur < min_ff);
   assign fifo_slot = (ptr_ff >= active) ? '0 : ptr_ff;
   assign slot      = (hit_ff || lru) ? slot_ff : fifo_slot;
   assign slot_plus = slot + CNT_W'(1);
   assign ev_valid  = !hit_ff && frame_valid_ff[slot[IDX_W-1:0]];
   assign stamp_next = (use_clock_ff == pgrep_pkg::STAMP_MAX) ? use_clock_ff
                                                             : use_clock_ff + 1'b1;

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pgrep_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = pgrep_pkg::ST_SEARCH;
            end
         end
         pgrep_pkg::ST_SEARCH: begin
            if (match || scan_last) begin
               state_in = pgrep_pkg::ST_UPDATE;
            end
         end
         pgrep_pkg::ST_UPDATE: begin
            if (upd_go) begin
               state_in = pgrep_pkg::ST_IDLE;
            end
         end
         default: state_in = pgrep_pkg::ST_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      upd_go    = 1'b0;
      unique case (state_ff)
         pgrep_pkg::ST_IDLE:   req_ready = 1'b1;
         pgrep_pkg::ST_SEARCH: issue     = (scan_ff < active);
         // hold the update while the previous result is still waiting
         pgrep_pkg::ST_UPDATE: upd_go    = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign page_wr  = upd_go && !hit_ff;
   assign stamp_wr = upd_go && lru;

   // ---------------- datapath next values ----------------
   always_comb begin
      frame_valid_in = frame_valid_ff;
      stamp_valid_in = stamp_valid_ff;
      use_clock_in   = use_clock_ff;
      ptr_in         = ptr_ff;
      faults_in      = faults_ff;
      accesses_in    = accesses_ff;
      page_in        = page_ff;
      scan_in        = scan_ff;
      data_valid_in  = 1'b0;
      didx_in        = scan_ff;
      hit_in         = hit_ff;
      slot_in        = slot_ff;
      min_in         = min_ff;
      victim_in      = victim_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (req_fire) begin
         page_in = req_page_number;
         scan_in = '0;
         hit_in  = 1'b0;
         if (req_start_run) begin
            frame_valid_in = '0;
            stamp_valid_in = '0;
            use_clock_in   = '0;
            ptr_in         = '0;
            faults_in      = '0;
            accesses_in    = pgrep_pkg::CNT_OUT_W'(1);
         end else if (accesses_ff != pgrep_pkg::COUNT_MAX) begin
            accesses_in = accesses_ff + 1'b1;
         end
      end

      if (issue) begin
         scan_in       = scan_ff + CNT_W'(1);
         data_valid_in = 1'b1;
      end

      if (state_ff == pgrep_pkg::ST_SEARCH && data_valid_ff) begin
         if (match) begin
            hit_in  = 1'b1;
            slot_in = didx_ff;
         end else if (lru && take_min) begin
            slot_in   = didx_ff;
            min_in    = stamp_cur;
            victim_in = page_rd;
         end else if (!lru && didx_ff == fifo_slot) begin
            victim_in = page_rd;
         end
      end

      if (upd_go) begin
         rsp_valid_in = 1'b1;
         if (lru) begin
            use_clock_in = stamp_next;
            stamp_valid_in[slot[IDX_W-1:0]] = 1'b1;
         end
         if (!hit_ff) begin
            frame_valid_in[slot[IDX_W-1:0]] = 1'b1;
            if (faults_ff != pgrep_pkg::COUNT_MAX) begin
               faults_in = faults_ff + 1'b1;
            end
            if (!lru) begin
               ptr_in = (slot_plus >= active) ? '0 : slot_plus;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pgrep_pkg::ST_IDLE;
         frame_valid_ff <= '0;
         stamp_valid_ff <= '0;
         use_clock_ff   <= '0;
         ptr_ff         <= '0;
         faults_ff      <= '0;
         accesses_ff    <= '0;
         data_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_valid_ff <= frame_valid_in;
         stamp_valid_ff <= stamp_valid_in;
         use_clock_ff   <= use_clock_in;
         ptr_ff         <= ptr_in;
         faults_ff      <= faults_in;
         accesses_ff    <= accesses_in;
         data_valid_ff  <= data_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff   <= page_in;
      scan_ff   <= scan_in;
      didx_ff   <= didx_in;
      hit_ff    <= hit_in;
      slot_ff   <= slot_in;
      min_ff    <= min_in;
      victim_ff <= victim_in;
      if (upd_go) begin
         rsp_hit_ff           <= hit_ff;
         rsp_frame_index_ff   <= pgrep_pkg::IDX_OUT_W'(slot);
         rsp_evicted_valid_ff <= ev_valid;
         rsp_evicted_page_ff  <= ev_valid ? victim_ff : '0;
         rsp_fault_count_ff   <= faults_in;
         rsp_access_count_ff  <= accesses_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_index_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_fault_count   = rsp_fault_count_ff;
   assign rsp_access_count  = rsp_access_count_ff;

   // ---------------- assertions ----------------
   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == pgrep_pkg::ST_UPDATE)
      else $error("result raised outside the update step");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == pgrep_pkg::ST_SEARCH |-> scan_ff <= active)
      else $error("scan ran past the frames in use");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_evicted_valid_ff))
      else $error("eviction reported on a hit");

   a_faults_le_accesses: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_fault_count_ff <= rsp_access_count_ff)
      else $error("more faults than accesses");

   a_clock_monotonic: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> use_clock_ff >= $past(use_clock_ff))
      else $error("use clock went backward without a run start");

endmodule
